/* rtl/core/ebpl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebpl_pkg
// Shared types and codes of the escape byte patch list encoder.
// ----------------------------------------------------------------------------
package ebpl_pkg;

  localparam logic [7:0] PREAMBLE_CODE = 8'hFD;
  localparam logic [7:0] TERM_CODE     = 8'hFF;
  localparam logic [7:0] ESCAPE_CODE   = 8'hFE;
  localparam logic [7:0] PREAMBLE_LEN  = 8'd3;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;

  localparam logic [SLOT_W-1:0] SLOT_TERM_A = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_DATA   = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_ENTRY  = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_TERM_B = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_TERM_2 = 3'd7;

  typedef struct packed {
    logic       pre;
    logic       term_a;
    logic       esc;
    logic [7:0] entry;
    logic [7:0] data;
    logic       term_b;
    logic       last;
  } cmd_t;

endpackage

/* rtl/core/ebpl_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebpl_if
// Valid/ready channels for input bytes and result items.
// ----------------------------------------------------------------------------
interface ebpl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ebpl_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] value;
  logic       run_end;
  logic       list_end;

  modport source (output valid, output kind, output value, output run_end,
                  output list_end, input ready);
  modport sink (input valid, input kind, input value, input run_end,
                input list_end, output ready);
endinterface

/* rtl/core/ebpl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebpl_front
// Classifies each input byte against the frame state and issues one command.
// ----------------------------------------------------------------------------
module ebpl_front #(
  parameter int LIST_CAPACITY   = 200,
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    split_offset,
  input  logic          in_valid,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic          cmd_ready,
  output ebpl_pkg::cmd_t cmd
);
  import ebpl_pkg::*;

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int XW = (PW > 8) ? PW : 8;
  localparam logic [XW-1:0] MAX_POS = XW'(MAX_FRAME_BYTES);
  localparam logic [7:0] ROOM_ONE = 8'(LIST_CAPACITY - 2);
  localparam logic [7:0] ROOM_TWO = 8'(LIST_CAPACITY - 1);

  logic [PW-1:0] byte_position;
  logic [7:0]    list_length;
  logic          part_one_closed;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] split_x;
  logic [7:0]    len0;
  logic [7:0]    len1;
  logic          closes;
  logic          closed_now;
  logic          in_frame;
  logic          room;
  logic          esc;
  logic          accept;

  always_comb begin
    pos_x      = XW'(byte_position);
    split_x    = XW'(split_offset);
    len0       = (byte_position == '0) ? PREAMBLE_LEN : list_length;
    closes     = !part_one_closed && (pos_x >= split_x);
    closed_now = part_one_closed || closes;
    len1       = len0 + 8'(closes);
    in_frame   = pos_x < MAX_POS;
    room       = closed_now ? (len1 < ROOM_TWO) : (len1 < ROOM_ONE);
    esc        = in_frame && (data_byte == ESCAPE_CODE) && room;
    accept     = in_valid && cmd_ready;

    cmd.pre    = (byte_position == '0);
    cmd.term_a = closes;
    cmd.esc    = esc;
    cmd.entry  = closed_now ? 8'(pos_x - split_x + XW'(1)) : 8'(pos_x + XW'(1));
    cmd.data   = data_byte;
    cmd.term_b = last_byte && !closed_now;
    cmd.last   = last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      list_length     <= '0;
      part_one_closed <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_position   <= '0;
        list_length     <= '0;
        part_one_closed <= 1'b0;
      end else begin
        byte_position   <= byte_position + PW'(in_frame);
        list_length     <= len1 + 8'(esc);
        part_one_closed <= closed_now;
      end
    end
  end

endmodule

/* rtl/core/ebpl_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebpl_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ebpl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  ebpl_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_pop,
  output ebpl_pkg::cmd_t rd_cmd
);
  import ebpl_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* rtl/core/ebpl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebpl_back
// Expands each command into its result items, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module ebpl_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  ebpl_pkg::cmd_t q_cmd,
  output logic           q_pop,
  ebpl_result_if.source  res
);
  import ebpl_pkg::*;

  cmd_t                 cur;
  logic [NUM_SLOTS-1:0] mask;
  logic [NUM_SLOTS-1:0] low;
  logic [NUM_SLOTS-1:0] mask_left;
  logic [NUM_SLOTS-1:0] mask_after;
  logic [NUM_SLOTS-1:0] mask_new;
  logic [SLOT_W-1:0]    idx;
  logic                 advance;
  logic                 emit;
  logic                 kind_next;
  logic [7:0]           value_next;
  logic                 list_end_next;

  always_comb begin
    advance    = !res.valid || res.ready;
    emit       = advance && (mask != '0);
    low        = mask & (~mask + NUM_SLOTS'(1));
    mask_left  = mask & ~low;
    mask_after = advance ? mask_left : mask;
    q_pop      = (mask_after == '0) && q_valid;
    mask_new   = {q_cmd.last, q_cmd.term_b, q_cmd.esc, 1'b1, q_cmd.term_a,
                  {3{q_cmd.pre}}};

    idx = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (low[k]) begin
        idx = SLOT_W'(k);
      end
    end

    list_end_next = 1'b0;
    case (idx)
      SLOT_TERM_A: begin
        kind_next  = 1'b1;
        value_next = TERM_CODE;
      end
      SLOT_DATA: begin
        kind_next  = 1'b0;
        value_next = cur.esc ? TERM_CODE : cur.data;
      end
      SLOT_ENTRY: begin
        kind_next  = 1'b1;
        value_next = cur.entry;
      end
      SLOT_TERM_B: begin
        kind_next  = 1'b1;
        value_next = TERM_CODE;
      end
      SLOT_TERM_2: begin
        kind_next     = 1'b1;
        value_next    = TERM_CODE;
        list_end_next = 1'b1;
      end
      default: begin
        kind_next  = 1'b1;
        value_next = PREAMBLE_CODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (emit) begin
      res.kind     <= kind_next;
      res.value    <= value_next;
      res.run_end  <= (mask_left == '0);
      res.list_end <= list_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      res.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        mask <= mask_new;
      end else begin
        mask <= mask_after;
      end
      if (advance) begin
        res.valid <= emit;
      end
    end
  end

endmodule

/* rtl/core/escape_byte_patch_list_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_byte_patch_list_encoder
// A byte's first result item passes through the command queue, the back part's
// command register and the output register. Throughput: one result item per
// cycle while the output is not stalled; a byte has one to seven result items.
// Reset clears the frame state, the queue and the output register; the
// split offset returns to 252.
// ----------------------------------------------------------------------------
module escape_byte_patch_list_encoder #(
  parameter int LIST_CAPACITY   = 200,
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  ebpl_byte_if.sink     byte_in,
  ebpl_result_if.source result_out
);
  import ebpl_pkg::*;

  logic [7:0] split_offset;
  cmd_t       front_cmd;
  cmd_t       head_cmd;
  logic       q_ready;
  logic       q_valid;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_offset <= 8'd252;
    end else if (cfg_we) begin
      split_offset <= cfg_data;
    end
  end

  assign byte_in.ready = q_ready;

  ebpl_front #(
    .LIST_CAPACITY  (LIST_CAPACITY),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .split_offset(split_offset),
    .in_valid    (byte_in.valid),
    .data_byte   (byte_in.data_byte),
    .last_byte   (byte_in.last_byte),
    .cmd_ready   (q_ready),
    .cmd         (front_cmd)
  );

  ebpl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(byte_in.valid),
    .wr_ready(q_ready),
    .wr_cmd  (front_cmd),
    .rd_valid(q_valid),
    .rd_pop  (q_pop),
    .rd_cmd  (head_cmd)
  );

  ebpl_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_cmd  (head_cmd),
    .q_pop  (q_pop),
    .res    (result_out)
  );

endmodule

/* rtl/core/ebpl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebpl_checker
// Port-level checks of the escape byte patch list encoder.
// ----------------------------------------------------------------------------
module ebpl_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [7:0] value,
  input logic       run_end,
  input logic       list_end
);
  import ebpl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(kind))
    else $error("Stalled result item changed.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result item shown right after reset.");

  a_list_end_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && list_end |-> run_end && kind && (value == TERM_CODE))
    else $error("List end is not a closing terminator.");

  a_data_not_list_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> !list_end)
    else $error("Data item marked as list end.");

endmodule

bind escape_byte_patch_list_encoder ebpl_checker u_ebpl_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(result_out.valid),
  .out_ready(result_out.ready),
  .kind     (result_out.kind),
  .value    (result_out.value),
  .run_end  (result_out.run_end),
  .list_end (result_out.list_end)
);
